@@ sv/cwel_pkg.sv @@
// ----------------------------------------------------------------------------
// cwel_pkg
// Shared types, codes and reset constants of the click wheel event latch.
// ----------------------------------------------------------------------------
package cwel_pkg;

  // Default geometry of the wheel status word
  localparam int POSITIONS_PER_TURN_DEF = 96;
  localparam int POSITION_SHIFT_DEF     = 16;
  localparam int TOUCH_BIT_DEF          = 30;
  localparam int BUTTON_BASE_BIT_DEF    = 8;

  localparam int POS_W    = 7;
  localparam int BTN_W    = 5;
  localparam int DELTA_W  = 8;
  localparam int SENS_W   = 6;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 8'sd127;
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = -8'sd127;

  localparam logic [CFG_W-1:0]  HEADER_MASK_RST  = 32'h8000_00FF;
  localparam logic [CFG_W-1:0]  HEADER_VALUE_RST = 32'h8000_001A;
  localparam logic [SENS_W-1:0] SENSITIVITY_RST  = 6'd4;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_DRAIN = 1'b1
  } cwel_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_MASK  = 2'd0,
    CFG_HEADER_VALUE = 2'd1,
    CFG_SENSITIVITY  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cwel_cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]  header_mask;
    logic [CFG_W-1:0]  header_value;
    logic [SENS_W-1:0] sensitivity;
  } cwel_cfg_t;

  typedef struct packed {
    logic                      armed;
    logic [POS_W-1:0]          position_reference;
    logic                      position_seeded;
    logic [BTN_W-1:0]          previous_buttons;
    logic                      previous_hold;
    logic [BTN_W-1:0]          pending_down_edges;
    logic signed [DELTA_W-1:0] delta_accumulator;
    logic                      last_touched;
    logic                      hold_edge_pending;
    logic                      reported_hold;
    logic                      bringup_pending;
    logic [BTN_W-1:0]          held_buttons;
  } cwel_state_t;

  typedef struct packed {
    logic                      event_valid;
    logic [BTN_W-1:0]          buttons;
    logic signed [DELTA_W-1:0] wheel_motion;
    logic                      touched;
    logic                      hold;
    logic                      bringup_request;
    logic [BTN_W-1:0]          live_buttons;
  } cwel_result_t;

endpackage

@@ sv/click_wheel_event_latch.sv @@
// ----------------------------------------------------------------------------
// click_wheel_event_latch
// Each input transfer's result is loaded into the output register. Throughput: one
//   item per cycle unless m_tready stalls a waiting result; the state registers update
//   in the accepting cycle, so the next item sees them at once, and the output register
//   refills as it drains. Reset: synchronous, active high; all latch state clears,
//   registers take their documented reset values and the output register empties.
// ----------------------------------------------------------------------------
module click_wheel_event_latch
  import cwel_pkg::*;
#(
  parameter int POSITIONS_PER_TURN = POSITIONS_PER_TURN_DEF,
  parameter int POSITION_SHIFT     = POSITION_SHIFT_DEF,
  parameter int TOUCH_BIT          = TOUCH_BIT_DEF,
  parameter int BUTTON_BASE_BIT    = BUTTON_BASE_BIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // [31:0] status_word, [32] hold_pin, [39:33] zero
  input  logic                 s_tuser,   // [0] op
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [4:0] buttons, [12:5] wheel_motion, [13] touched,
                                          // [14] hold, [15] bringup_request,
                                          // [20:16] live_buttons, [23:21] zero
  output logic                 m_tuser    // [0] event_valid
);

  cwel_cfg_t    cfg;
  cwel_state_t  state;
  cwel_state_t  state_next;
  cwel_result_t result;
  cwel_result_t out_reg;
  cwel_op_t     op;
  logic         s_xfer;

  assign op     = cwel_op_t'(s_tuser);
  // Take a new item whenever the output register is empty or is being emptied
  assign s_tready = ~m_tvalid | m_tready;
  assign s_xfer   = s_tvalid & s_tready;

  // Configuration registers; writes to the spare index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_mask  <= HEADER_MASK_RST;
      cfg.header_value <= HEADER_VALUE_RST;
      cfg.sensitivity  <= SENSITIVITY_RST;
    end else if (cfg_we) begin
      unique case (cwel_cfg_idx_t'(cfg_index))
        CFG_HEADER_MASK:  cfg.header_mask  <= cfg_data;
        CFG_HEADER_VALUE: cfg.header_value <= cfg_data;
        CFG_SENSITIVITY:  cfg.sensitivity  <= cfg_data[SENS_W-1:0];
        CFG_UNUSED: ;
        default: ;
      endcase
    end
  end

  // Decode the item against the current latch state in a single pass
  cwel_step #(
    .POSITIONS_PER_TURN (POSITIONS_PER_TURN),
    .POSITION_SHIFT     (POSITION_SHIFT),
    .TOUCH_BIT          (TOUCH_BIT),
    .BUTTON_BASE_BIT    (BUTTON_BASE_BIT)
  ) u_step (
    .cfg         (cfg),
    .state       (state),
    .op          (op),
    .status_word (s_tdata[31:0]),
    .hold_pin    (s_tdata[32]),
    .state_next  (state_next),
    .result      (result)
  );

  // Latch state: advance only on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s_xfer) begin
      state <= state_next;
    end
  end

  // Output register: load on transfer, drop the valid flag once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      out_reg <= result;
    end
  end

  assign m_tuser = out_reg.event_valid;
  assign m_tdata = {3'b000, out_reg.live_buttons, out_reg.bringup_request, out_reg.hold,
                    out_reg.touched, out_reg.wheel_motion, out_reg.buttons};

  // A tick never reports an event
  a_tick_no_event: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && op == OP_TICK) |=> (m_tvalid && !m_tuser))
    else $error("tick produced an event");

  // A drain leaves nothing latched behind
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && op == OP_DRAIN) |=> (state.delta_accumulator == '0 &&
      state.pending_down_edges == '0 && !state.hold_edge_pending && !state.bringup_pending))
    else $error("drain left latched state");

  // The accumulator saturates symmetrically and never reaches the most negative code
  a_delta_range: assert property (@(posedge clk) disable iff (rst)
    state.delta_accumulator != 8'h80)
    else $error("wheel accumulator out of range");

  // Back-pressure only while a result is waiting
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with no waiting result");

endmodule

@@ sv/cwel_step.sv @@
// ----------------------------------------------------------------------------
// cwel_step
// Next-state and result logic for one tick sample or drain.
// ----------------------------------------------------------------------------
module cwel_step
  import cwel_pkg::*;
#(
  parameter int POSITIONS_PER_TURN = POSITIONS_PER_TURN_DEF,
  parameter int POSITION_SHIFT     = POSITION_SHIFT_DEF,
  parameter int TOUCH_BIT          = TOUCH_BIT_DEF,
  parameter int BUTTON_BASE_BIT    = BUTTON_BASE_BIT_DEF
) (
  input  cwel_cfg_t    cfg,
  input  cwel_state_t  state,
  input  cwel_op_t     op,
  input  logic [31:0]  status_word,
  input  logic         hold_pin,
  output cwel_state_t  state_next,
  output cwel_result_t result
);

  localparam logic signed [9:0] TURN_S  = 10'(POSITIONS_PER_TURN);
  localparam logic signed [9:0] HALF_S  = 10'(POSITIONS_PER_TURN / 2);
  localparam logic [7:0]        POS_LIM = 8'(POSITIONS_PER_TURN);

  logic                   hold;
  logic [POS_W-1:0]       pos;
  logic                   touch;
  logic [BTN_W-1:0]       map;
  logic                   header_ok;
  logic                   pos_ok;
  logic [POS_W-1:0]       ref_eff;
  logic signed [9:0]      diff_raw;
  logic signed [9:0]      diff;
  logic signed [9:0]      thresh;
  logic                   step_fire;
  logic signed [9:0]      sum;
  logic signed [DELTA_W-1:0] sum_sat;

  assign hold      = ~hold_pin;
  assign pos       = status_word[POSITION_SHIFT +: POS_W];
  assign touch     = status_word[TOUCH_BIT];
  assign map       = status_word[BUTTON_BASE_BIT +: BTN_W];
  assign header_ok = (status_word & cfg.header_mask) == cfg.header_value;
  assign pos_ok    = {1'b0, pos} < POS_LIM;
  assign ref_eff   = state.position_seeded ? state.position_reference : pos;
  assign diff_raw  = $signed({3'b000, pos}) - $signed({3'b000, ref_eff});
  assign thresh    = $signed({4'b0000, cfg.sensitivity});

  // wrap into (-half, +half]
  always_comb begin
    if (diff_raw > HALF_S) begin
      diff = diff_raw - TURN_S;
    end else if (diff_raw <= -HALF_S) begin
      diff = diff_raw + TURN_S;
    end else begin
      diff = diff_raw;
    end
  end

  assign step_fire = (diff >= thresh) || (diff <= -thresh);
  assign sum = $signed({{2{state.delta_accumulator[DELTA_W-1]}}, state.delta_accumulator})
             + diff;

  always_comb begin
    if (sum > 10'sd127) begin
      sum_sat = DELTA_MAX;
    end else if (sum < -10'sd127) begin
      sum_sat = DELTA_MIN;
    end else begin
      sum_sat = sum[DELTA_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    unique case (op)
      OP_DRAIN: begin
        result.bringup_request = state.bringup_pending;
        if (state.hold_edge_pending) begin
          result.event_valid = 1'b1;
          result.hold        = state.reported_hold;
        end else if (state.pending_down_edges != '0 || state.delta_accumulator != '0) begin
          result.event_valid  = 1'b1;
          result.buttons      = state.pending_down_edges;
          result.wheel_motion = state.delta_accumulator;
          result.touched      = state.last_touched;
        end
        state_next.bringup_pending    = 1'b0;
        state_next.hold_edge_pending  = 1'b0;
        state_next.pending_down_edges = '0;
        state_next.delta_accumulator  = '0;
      end
      OP_TICK: begin
        priority if (!state.armed || hold != state.previous_hold) begin
          state_next.previous_hold      = hold;
          state_next.reported_hold      = hold;
          state_next.hold_edge_pending  = state.armed;
          state_next.bringup_pending    = state.armed & ~hold;
          state_next.armed              = 1'b1;
          state_next.position_seeded    = 1'b0;
          state_next.previous_buttons   = '0;
          state_next.pending_down_edges = '0;
          state_next.delta_accumulator  = '0;
          state_next.last_touched       = 1'b0;
          state_next.held_buttons       = '0;
        end else if (!hold && !state.bringup_pending && header_ok && pos_ok) begin
          if (touch) begin
            state_next.position_seeded    = 1'b1;
            state_next.position_reference = step_fire ? pos : ref_eff;
            if (step_fire && diff != '0) begin
              state_next.delta_accumulator = sum_sat;
            end
          end else begin
            state_next.position_seeded = 1'b0;
          end
          state_next.pending_down_edges = state.pending_down_edges | (map & ~state.previous_buttons);
          state_next.previous_buttons   = map;
          state_next.held_buttons       = map;
          state_next.last_touched       = touch;
        end else begin
          // held, bring-up pending or dropped sample: keep state
          state_next = state;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
    result.live_buttons = state_next.held_buttons;
  end

endmodule

@@ bench/tb_click_wheel_event_latch.sv @@
// ----------------------------------------------------------------------------
// tb_click_wheel_event_latch
// Self-checking bench for the click wheel event latch. A queue of tick samples
// and drains feeds a stream driver with random gaps, a sink applies random
// back-pressure, and a monitor scores every result transfer against an
// in-bench decoder of the wheel, button and hold behaviour. Configuration is
// reloaded between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_click_wheel_event_latch;
  import cwel_pkg::*;

  localparam int TURN           = POSITIONS_PER_TURN_DEF;
  localparam int HALF_TURN      = POSITIONS_PER_TURN_DEF / 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 65;
  // bits of the status word that carry touch, position and buttons
  localparam logic [31:0] FIELD_BITS = 32'h407F_1F00;

  typedef struct packed {
    cwel_op_t    op;
    logic [31:0] sw;
    logic        pin;
  } wheel_item_t;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;
  logic                 m_tuser;

  // decoder copy of the configuration
  logic [31:0]       hdr_mask  = HEADER_MASK_RST;
  logic [31:0]       hdr_value = HEADER_VALUE_RST;
  logic [SENS_W-1:0] step_min  = SENSITIVITY_RST;

  // decoder copy of the latch state
  logic                      is_armed      = 1'b0;
  logic [POS_W-1:0]          pos_ref       = '0;
  logic                      pos_ref_valid = 1'b0;
  logic [BTN_W-1:0]          last_map      = '0;
  logic                      last_hold     = 1'b0;
  logic [BTN_W-1:0]          press_latch   = '0;
  logic signed [DELTA_W-1:0] wheel_acc     = '0;
  logic                      finger_down   = 1'b0;
  logic                      hold_event    = 1'b0;
  logic                      hold_level    = 1'b0;
  logic                      wake_pending  = 1'b0;
  logic [BTN_W-1:0]          held_map      = '0;

  wheel_item_t  queued_items[$];
  cwel_result_t awaited_reports[$];
  wheel_item_t  drv_item;
  cwel_result_t seen_report;
  cwel_result_t want_report;

  bit idle_on  = 1'b1;
  bit in_taken = 1'b0;
  int gap_left = 0;
  int sink_wait = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // stimulus generator state
  logic       gen_pin   = 1'b1;
  logic       gen_touch = 1'b1;
  int         gen_pos   = 0;
  logic [4:0] gen_map   = '0;

  click_wheel_event_latch DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Forget the decode state and the pending latches
  function automatic void drop_latches();
    pos_ref_valid = 1'b0;
    last_map      = '0;
    press_latch   = '0;
    wheel_acc     = '0;
    finger_down   = 1'b0;
    held_map      = '0;
  endfunction

  // Advance the decoder by one accepted item and return the report it yields
  function automatic cwel_result_t decode_wheel_item(cwel_op_t op, logic [31:0] sw,
                                                     logic pin);
    cwel_result_t r;
    logic         held;
    logic         touch;
    logic [4:0]   map;
    int           pos;
    int           d;
    int           th;
    int           step;
    int           acc;
    r    = '0;
    held = !pin;
    if (op == OP_TICK) begin
      if (!is_armed) begin
        // first tick only seeds the hold state
        last_hold    = held;
        hold_level   = held;
        hold_event   = 1'b0;
        wake_pending = 1'b0;
        drop_latches();
        is_armed     = 1'b1;
      end else if (held != last_hold) begin
        last_hold    = held;
        wake_pending = !held;
        drop_latches();
        hold_level   = held;
        hold_event   = 1'b1;
      end else if (!held && !wake_pending && ((sw & hdr_mask) == hdr_value)) begin
        pos = int'(sw[POSITION_SHIFT_DEF +: POS_W]);
        if (pos < TURN) begin
          touch = sw[TOUCH_BIT_DEF];
          step  = 0;
          if (touch) begin
            if (!pos_ref_valid) begin
              pos_ref       = pos[POS_W-1:0];
              pos_ref_valid = 1'b1;
            end
            // wrap into (-half turn, +half turn]
            d = pos - int'(pos_ref);
            if (d > HALF_TURN)
              d -= TURN;
            else if (d <= -HALF_TURN)
              d += TURN;
            th = int'(step_min);
            if (d >= th || d <= -th) begin
              step    = d;
              pos_ref = pos[POS_W-1:0];
            end
          end else begin
            pos_ref_valid = 1'b0;
          end
          map         = sw[BUTTON_BASE_BIT_DEF +: BTN_W];
          press_latch = press_latch | (map & ~last_map);
          last_map    = map;
          held_map    = map;
          if (step != 0) begin
            acc = wheel_acc;
            acc = acc + step;
            if (acc > 127) acc = 127;
            if (acc < -127) acc = -127;
            wheel_acc = acc[DELTA_W-1:0];
          end
          finger_down = touch;
        end
      end
    end else begin
      r.bringup_request = wake_pending;
      wake_pending      = 1'b0;
      if (hold_event) begin
        // a hold edge outranks any latched motion
        r.event_valid = 1'b1;
        r.hold        = hold_level;
      end else if (press_latch != '0 || wheel_acc != '0) begin
        r.event_valid  = 1'b1;
        r.buttons      = press_latch;
        r.wheel_motion = wheel_acc;
        r.touched      = finger_down;
      end
      hold_event  = 1'b0;
      press_latch = '0;
      wheel_acc   = '0;
    end
    r.live_buttons = held_map;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Build a status word; a good header matches the live configuration
  function automatic logic [31:0] make_status(logic touch, logic [6:0] pos, logic [4:0] map,
                                              bit good);
    logic [31:0] w;
    w = $urandom;
    w[TOUCH_BIT_DEF]                = touch;
    w[POSITION_SHIFT_DEF +: POS_W]  = pos;
    w[BUTTON_BASE_BIT_DEF +: BTN_W] = map;
    if (good)
      w = (w & ~hdr_mask) | (hdr_value & hdr_mask);
    else
      w = (w & ~hdr_mask) | (~hdr_value & hdr_mask);
    return w;
  endfunction

  task automatic push_tick(logic touch, logic [6:0] pos, logic [4:0] map, bit good,
                           logic pin);
    wheel_item_t it;
    it.op  = OP_TICK;
    it.sw  = make_status(touch, pos, map, good);
    it.pin = pin;
    queued_items.push_back(it);
  endtask

  // Drain payload is ignored by the block, so fill it with noise
  task automatic push_drain();
    wheel_item_t it;
    it.op  = OP_DRAIN;
    it.sw  = $urandom;
    it.pin = 1'($urandom_range(0, 1));
    queued_items.push_back(it);
  endtask

  // Mostly coherent wheel motion with occasional hold flips, drains and junk
  task automatic queue_random(int n);
    int   k;
    int   r;
    int   mv;
    logic [6:0] pos;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        push_drain();
      end else begin
        if (r < 21)
          gen_pin = !gen_pin;
        if (gen_touch ? ($urandom_range(0, 99) < 5) : ($urandom_range(0, 99) < 30))
          gen_touch = !gen_touch;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          mv      = $urandom_range(0, 24) - 12;
          gen_pos = (gen_pos + mv + TURN) % TURN;
        end else if (r < 88) begin
          mv      = $urandom_range(0, 96) - 48;
          gen_pos = (gen_pos + mv + TURN) % TURN;
        end else begin
          gen_pos = $urandom_range(0, TURN - 1);
        end
        pos = gen_pos[6:0];
        if ($urandom_range(0, 99) < 5)
          pos = 7'($urandom_range(TURN, 127));
        if ($urandom_range(0, 3) == 0)
          gen_map = gen_map ^ (5'd1 << $urandom_range(0, 4));
        if ($urandom_range(0, 99) < 3)
          gen_map = 5'($urandom_range(0, 31));
        push_tick(gen_touch, pos, gen_map, $urandom_range(0, 99) < 92, gen_pin);
      end
    end
  endtask

  // Hold until the queue is empty and every awaited report has come back
  task automatic wait_drained();
    while (queued_items.size() != 0 || s_tvalid || awaited_reports.size() != 0)
      @(posedge clk);
  endtask

  // Load all three registers on back-to-back write cycles
  task automatic load_config(logic [31:0] mask, logic [31:0] value, logic [SENS_W-1:0] sens);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER_MASK;
    cfg_data  <= mask;
    @(negedge clk);
    cfg_index <= CFG_HEADER_VALUE;
    cfg_data  <= value;
    @(negedge clk);
    cfg_index <= CFG_SENSITIVITY;
    cfg_data  <= {{(CFG_W-SENS_W){1'b0}}, sens};
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Source side: present queued items, advance after each transfer, insert gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (queued_items.size() != 0) begin
        drv_item = queued_items.pop_front();
        s_tuser  <= drv_item.op;
        s_tdata  <= {7'd0, drv_item.pin, drv_item.sw};
        s_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < 25)
          gap_left = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 20)
        sink_wait = pick_gap();
    end
  end

  // Monitor: track register writes, predict on input transfers, score outputs
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER_MASK:  hdr_mask  = cfg_data;
          CFG_HEADER_VALUE: hdr_value = cfg_data;
          CFG_SENSITIVITY:  step_min  = cfg_data[SENS_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        awaited_reports.push_back(decode_wheel_item(cwel_op_t'(s_tuser), s_tdata[31:0],
                                                    s_tdata[32]));
      end
      if (m_tvalid && m_tready) begin
        seen_report.event_valid     = m_tuser;
        seen_report.buttons         = m_tdata[4:0];
        seen_report.wheel_motion    = m_tdata[12:5];
        seen_report.touched         = m_tdata[13];
        seen_report.hold            = m_tdata[14];
        seen_report.bringup_request = m_tdata[15];
        seen_report.live_buttons    = m_tdata[20:16];
        if (awaited_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer tuser=%0b tdata=%06h", $time,
                   m_tuser, m_tdata);
        end else begin
          want_report = awaited_reports.pop_front();
          if (seen_report !== want_report) begin
            errors++;
            $display({"%0t: result mismatch",
                      " expected ev=%0b btn=%02h dl=%0d tch=%0b hold=%0b br=%0b live=%02h",
                      " actual ev=%0b btn=%02h dl=%0d tch=%0b hold=%0b br=%0b live=%02h"},
                     $time, want_report.event_valid, want_report.buttons,
                     want_report.wheel_motion, want_report.touched, want_report.hold,
                     want_report.bringup_request, want_report.live_buttons,
                     seen_report.event_valid, seen_report.buttons,
                     seen_report.wheel_motion, seen_report.touched, seen_report.hold,
                     seen_report.bringup_request, seen_report.live_buttons);
          end
        end
      end
      // watchdog: count cycles with no transfer on either side
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_click_wheel_event_latch NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          p;
    logic [31:0] mask;
    logic [31:0] value;
    logic [5:0]  sens;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: drain before the first tick, then arm with hold engaged
    push_drain();
    push_tick(1'b1, 7'd10, 5'd0, 1'b1, 1'b0);
    push_tick(1'b1, 7'd10, 5'd0, 1'b1, 1'b0);   // held: ignored
    push_tick(1'b1, 7'd10, 5'd0, 1'b1, 1'b1);   // release edge, bring-up pending
    push_tick(1'b1, 7'd20, 5'd3, 1'b1, 1'b1);   // ignored while bring-up pending
    push_drain();                               // hold edge event with bring-up
    // Wrap and threshold: below threshold, wrapped step, both half-turn limits
    push_tick(1'b1, 7'd0,  5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd95, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd91, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd43, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd91, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd43, 5'd0, 1'b1, 1'b1);   // saturate high
    push_tick(1'b1, 7'd91, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd91, 5'd31, 1'b1, 1'b1);  // every button down
    push_drain();
    push_drain();                               // nothing latched
    // Dropped samples: bad header, position just out of range, top position
    push_tick(1'b1, 7'd50, 5'd0, 1'b0, 1'b1);
    push_tick(1'b1, 7'd96, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd127, 5'd0, 1'b1, 1'b1);
    // Saturate low with steps of -47
    push_tick(1'b1, 7'd44, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd93, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd46, 5'd0, 1'b1, 1'b1);
    push_tick(1'b1, 7'd95, 5'd0, 1'b1, 1'b1);
    push_drain();
    push_tick(1'b0, 7'd30, 5'd4, 1'b1, 1'b1);   // finger lifted
    push_tick(1'b1, 7'd30, 5'd0, 1'b1, 1'b0);   // hold engaged
    push_drain();
    push_tick(1'b1, 7'd30, 5'd0, 1'b1, 1'b1);   // hold released
    push_drain();
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      repeat (2) @(posedge clk);
      sens = 6'($urandom_range(1, 48));
      case (p)
        0: begin mask = HEADER_MASK_RST; value = HEADER_VALUE_RST; sens = 6'd1; end
        1: begin mask = 32'h0; value = 32'h0; sens = 6'd48; end
        2: begin mask = 32'hFFFF_FFFF; value = $urandom; end
        3: begin mask = 32'h0000_00F0; value = 32'h0000_000F; end  // never matches
        default: begin
          mask  = $urandom & ~FIELD_BITS;
          value = $urandom & mask;
        end
      endcase
      load_config(mask, value, sens);
      @(posedge clk);
      idle_on = (p % 3) != 2;
      if (p == 5) begin
        // pause the source until everything is back, then carry on
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && awaited_reports.size() == 0)
      $display("tb_click_wheel_event_latch OK");
    else
      $display("tb_click_wheel_event_latch NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cwel_pkg.sv
sv/cwel_step.sv
sv/click_wheel_event_latch.sv
bench/tb_click_wheel_event_latch.sv
